/* hdl/vbp_pkg.sv */
// Package for the SNMP response varbind parser.
// Holds types, protocol constants and small helper functions; no dependencies.
package vbp_pkg;

  localparam int unsigned PACKET_MAX       = 2048;
  localparam int unsigned MAX_LENGTH_BYTES = 3;

  localparam int unsigned LEN_W = $clog2(PACKET_MAX + 2);
  localparam int unsigned LB_W  = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned ACC_W = LEN_W + 8;

  localparam int unsigned RES_MAX = 3;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] TAG_SEQ     = 8'h30;
  localparam logic [7:0] TAG_INT     = 8'h02;
  localparam logic [7:0] TAG_OCTETS  = 8'h04;
  localparam logic [7:0] TAG_RESP    = 8'ha2;
  localparam logic [7:0] TAG_OID     = 8'h06;
  localparam logic [7:0] LONG_FORM   = 8'h80;
  localparam logic [6:0] LEN_CNT_MSK = 7'h7f;

  localparam logic [3:0] EL_OUTER    = 4'd0;
  localparam logic [3:0] EL_PDU      = 4'd3;
  localparam logic [3:0] EL_VB_LIST  = 4'd7;
  localparam logic [3:0] EL_VARBIND  = 4'd8;
  localparam logic [3:0] EL_OID      = 4'd9;
  localparam logic [3:0] EL_VALUE    = 4'd10;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN0 = 2'd1,
    PH_LENX = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ARC    = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TAG   = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] item_value;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]       cnt;
    res_t [RES_MAX-1:0] items;
  } push_t;

  function automatic logic [7:0] want_tag(input logic [3:0] stage);
    logic [7:0] tag;
    case (stage)
      4'd0, 4'd7, 4'd8:       tag = TAG_SEQ;
      4'd1, 4'd4, 4'd5, 4'd6: tag = TAG_INT;
      4'd2:                   tag = TAG_OCTETS;
      4'd3:                   tag = TAG_RESP;
      4'd9:                   tag = TAG_OID;
      default:                tag = 8'h00;
    endcase
    return tag;
  endfunction

  function automatic logic is_container(input logic [3:0] stage);
    return (stage == EL_OUTER) || (stage == EL_PDU) ||
           (stage == EL_VB_LIST) || (stage == EL_VARBIND);
  endfunction

  function automatic res_t mk_res(input kind_e kind, input logic [7:0] val,
                                  input status_e st);
    res_t r;
    r.kind       = kind;
    r.item_value = val;
    r.status     = st;
    r.last       = (kind == KIND_STATUS);
    return r;
  endfunction

endpackage

/* hdl/snmp_response_varbind_parser_top.sv */
// SNMP response varbind parser: one packet byte per input transaction. Each
// byte is parsed in the cycle it is accepted, and its results go into a
// four-entry result queue that drives the output channel. A byte is taken
// every cycle while bytes give at most one result each and output is ready;
// a first OID byte gives two arcs, the last value byte adds the ok status, and
// a byte that ends the packet early can add a status, so such a byte can give
// two or three results, and input ready drops while the queue holds more than
// one result. Results per packet: OID arcs (kind 0), value bytes (kind 1), then
// one status (kind 2, last high).
// Depends on vbp_pkg, vbp_parser and vbp_res_fifo.
module snmp_response_varbind_parser_top import vbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       packet_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] item_value_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  push_t push;
  res_t  head;
  logic  room;
  logic  fire;

  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  vbp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (data_byte_i),
    .packet_end_i (packet_end_i),
    .push_o       (push)
  );

  vbp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign kind_o       = head.kind;
  assign item_value_o = head.item_value;
  assign status_o     = head.status;
  assign last_o       = head.last;

endmodule

/* hdl/vbp_parser.sv */
// Per-byte BER parse state and step logic; emits up to three results per byte.
// Depends on vbp_pkg.
module vbp_parser import vbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       packet_end_i,
  output push_t      push_o
);

  logic [3:0]       stage_q, stage_d;
  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] accum_q, accum_d;
  logic [LB_W-1:0]  lbl_q, lbl_d;
  logic [LEN_W-1:0] bound_q, bound_d;
  logic [LEN_W-1:0] content_q, content_d;
  logic             first_q, first_d;
  logic             finished_q, finished_d;

  logic [ACC_W-1:0] acc_wide;
  logic [15:0]      prod;
  logic [2:0]       arc_hi;
  logic [7:0]       arc_lo;
  logic [6:0]       len_cnt;

  assign acc_wide = {accum_q, data_byte_i};
  assign prod     = 16'(data_byte_i) * 16'd205;
  assign arc_hi   = prod[15:13];
  assign arc_lo   = data_byte_i - ({2'b00, arc_hi, 3'b000} + {arc_hi, 5'b00000});
  assign len_cnt  = data_byte_i[6:0] & LEN_CNT_MSK;

  always_comb begin
    logic             len_ok;
    logic [LEN_W-1:0] len;
    logic [1:0]       n;
    res_t [RES_MAX-1:0] res;
    stage_d    = stage_q;
    phase_d    = phase_q;
    accum_d    = accum_q;
    lbl_d      = lbl_q;
    bound_d    = bound_q;
    content_d  = content_q;
    first_d    = first_q;
    finished_d = finished_q;
    len_ok     = 1'b0;
    len        = '0;
    n          = '0;
    res        = '0;
    if (fire_i) begin
      if (!finished_q) begin
        if (bound_q == '0) begin
          res[n] = mk_res(KIND_STATUS, 8'h00, ST_TRUNC);
          n = n + 2'd1;
          finished_d = 1'b1;
        end else begin
          bound_d = bound_q - 1'b1;
          case (phase_q)
            PH_TAG: begin
              if (stage_q < EL_VALUE && data_byte_i != want_tag(stage_q)) begin
                res[n] = mk_res(KIND_STATUS, 8'h00, ST_TAG);
                n = n + 2'd1;
                finished_d = 1'b1;
              end else begin
                phase_d = PH_LEN0;
              end
            end
            PH_LEN0: begin
              if ((data_byte_i & LONG_FORM) == 8'h00) begin
                len_ok = 1'b1;
                len    = LEN_W'(data_byte_i);
              end else if (len_cnt == 7'd0) begin
                len_ok = 1'b1;
              end else if (32'(len_cnt) > MAX_LENGTH_BYTES) begin
                res[n] = mk_res(KIND_STATUS, 8'h00, ST_TRUNC);
                n = n + 2'd1;
                finished_d = 1'b1;
              end else begin
                accum_d = '0;
                lbl_d   = LB_W'(len_cnt);
                phase_d = PH_LENX;
              end
            end
            PH_LENX: begin
              if (32'(acc_wide) > PACKET_MAX) begin
                accum_d = LEN_W'(PACKET_MAX + 1);
              end else begin
                accum_d = LEN_W'(acc_wide);
              end
              if (lbl_q != '0) begin
                lbl_d = lbl_q - 1'b1;
              end
              if (lbl_d == '0) begin
                len_ok = 1'b1;
                len    = accum_d;
              end
            end
            PH_BODY: begin
              if (content_q != '0) begin
                content_d = content_q - 1'b1;
              end
              if (stage_q == EL_OID) begin
                if (first_q) begin
                  first_d = 1'b0;
                  res[n] = mk_res(KIND_ARC, {5'b00000, arc_hi}, ST_OK);
                  n = n + 2'd1;
                  res[n] = mk_res(KIND_ARC, arc_lo, ST_OK);
                  n = n + 2'd1;
                end else begin
                  res[n] = mk_res(KIND_ARC, data_byte_i, ST_OK);
                  n = n + 2'd1;
                end
              end else if (stage_q >= EL_VALUE) begin
                res[n] = mk_res(KIND_VALUE, data_byte_i, ST_OK);
                n = n + 2'd1;
              end
              if (content_d == '0) begin
                if (stage_q >= EL_VALUE) begin
                  res[n] = mk_res(KIND_STATUS, 8'h00, ST_OK);
                  n = n + 2'd1;
                  finished_d = 1'b1;
                end else begin
                  stage_d = stage_q + 4'd1;
                  phase_d = PH_TAG;
                end
              end
            end
            default: phase_d = PH_TAG;
          endcase
          if (len_ok) begin
            if (32'(len) > PACKET_MAX) begin
              res[n] = mk_res(KIND_STATUS, 8'h00, ST_TRUNC);
              n = n + 2'd1;
              finished_d = 1'b1;
            end else if (stage_q < EL_OID && is_container(stage_q)) begin
              if (len < bound_d) begin
                bound_d = len;
              end
              stage_d = stage_q + 4'd1;
              phase_d = PH_TAG;
            end else if (len > bound_d) begin
              res[n] = mk_res(KIND_STATUS, 8'h00, ST_TRUNC);
              n = n + 2'd1;
              finished_d = 1'b1;
            end else begin
              content_d = len;
              if (len != '0) begin
                phase_d = PH_BODY;
              end else if (stage_q >= EL_VALUE) begin
                res[n] = mk_res(KIND_STATUS, 8'h00, ST_OK);
                n = n + 2'd1;
                finished_d = 1'b1;
              end else begin
                stage_d = stage_q + 4'd1;
                phase_d = PH_TAG;
              end
            end
          end
        end
      end
      if (packet_end_i) begin
        if (!finished_d) begin
          res[n] = mk_res(KIND_STATUS, 8'h00, ST_TRUNC);
          n = n + 2'd1;
        end
        stage_d    = EL_OUTER;
        phase_d    = PH_TAG;
        accum_d    = '0;
        lbl_d      = '0;
        bound_d    = LEN_W'(PACKET_MAX);
        content_d  = '0;
        first_d    = 1'b1;
        finished_d = 1'b0;
      end
    end
    push_o.cnt   = n;
    push_o.items = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= EL_OUTER;
      phase_q    <= PH_TAG;
      accum_q    <= '0;
      lbl_q      <= '0;
      bound_q    <= LEN_W'(PACKET_MAX);
      content_q  <= '0;
      first_q    <= 1'b1;
      finished_q <= 1'b0;
    end else begin
      stage_q    <= stage_d;
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      lbl_q      <= lbl_d;
      bound_q    <= bound_d;
      content_q  <= content_d;
      first_q    <= first_d;
      finished_q <= finished_d;
    end
  end

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q <= EL_VALUE)
    else $error("stage beyond value element");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && packet_end_i |=> stage_q == EL_OUTER && !finished_q &&
      phase_q == PH_TAG && bound_q == LEN_W'(PACKET_MAX))
    else $error("parser not back at start after packet end");

  a_bound_narrows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !packet_end_i |=> bound_q <= $past(bound_q))
    else $error("byte bound grew inside a packet");

  a_status_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q && !packet_end_i |-> push_o.cnt == 2'd0)
    else $error("result after status given");

endmodule

/* hdl/vbp_res_fifo.sv */
// Four-entry result queue; takes up to three results per cycle, gives one while ready_i is high.
// Depends on vbp_pkg.
module vbp_res_fifo import vbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  head_o
);

  res_t [Q_DEPTH-1:0] mem_q;
  logic [Q_AW-1:0]    wr_q, wr_d;
  logic [Q_AW-1:0]    rd_q, rd_d;
  logic [Q_CW-1:0]    cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= Q_CW'(Q_DEPTH - RES_MAX));
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  assign wr_d  = wr_q + Q_AW'(push_i.cnt);
  assign rd_d  = rd_q + Q_AW'(pop);
  assign cnt_d = cnt_q + Q_CW'(push_i.cnt) - Q_CW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_q + Q_AW'(i)] <= push_i.items[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    Q_AW'(wr_q - rd_q) == Q_AW'(cnt_q))
    else $error("queue pointers and count disagree");

endmodule

/* tb/snmp_response_varbind_parser_top_test.sv */
// Testbench for snmp_response_varbind_parser_top: feeds directed bytes and SNMP response
// packets, some spoiled or random, one byte per transaction; checks OID arcs, value bytes and final status.
// Depends on vbp_pkg and the parser RTL; the expected results come from an in-bench model.
module snmp_response_varbind_parser_top_test;
  import vbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 20;

  localparam logic [7:0] TAG_CHAIN [10] = '{
    TAG_SEQ, TAG_INT, TAG_OCTETS, TAG_RESP, TAG_INT,
    TAG_INT, TAG_INT, TAG_SEQ, TAG_SEQ, TAG_OID
  };

  typedef struct {
    kind_e      kind;
    logic [7:0] value;
    status_e    status;
    logic       last;
  } result_t;

  typedef logic [7:0] byte_q_t[$];

  class varbind_scoreboard;
    result_t              pending_results[$];
    int unsigned          errors;
    logic [3:0]           stage;
    phase_e               phase;
    logic [LEN_W-1:0]     len_accum;
    logic [LB_W-1:0]      len_bytes;
    logic [LEN_W-1:0]     bound;
    logic [LEN_W-1:0]     content;
    bit                   first_arc;
    bit                   done;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      stage     = EL_OUTER;
      phase     = PH_TAG;
      len_accum = '0;
      len_bytes = '0;
      bound     = LEN_W'(PACKET_MAX);
      content   = '0;
      first_arc = 1'b1;
      done      = 1'b0;
    endfunction

    function void push(kind_e k, logic [7:0] v, status_e s);
      result_t r;
      r.kind   = k;
      r.value  = v;
      r.status = s;
      r.last   = (k == KIND_STATUS);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void conclude(status_e s);
      done = 1'b1;
      push(KIND_STATUS, 8'h00, s);
    endfunction

    function void length_known(int unsigned len);
      if (len > PACKET_MAX) begin
        conclude(ST_TRUNC);
        return;
      end
      if (stage == EL_OUTER || stage == EL_PDU || stage == EL_VB_LIST ||
          stage == EL_VARBIND) begin
        if (len < bound) bound = LEN_W'(len);
        stage = stage + 1'b1;
        phase = PH_TAG;
        return;
      end
      if (len > bound) begin
        conclude(ST_TRUNC);
        return;
      end
      content = LEN_W'(len);
      if (len != 0) begin
        phase = PH_BODY;
        return;
      end
      if (stage >= EL_VALUE) begin
        conclude(ST_OK);
      end else begin
        stage = stage + 1'b1;
        phase = PH_TAG;
      end
    endfunction

    // Return 1 when the byte was parsed rather than dropped after a status.
    function bit note_byte(logic [7:0] b, logic pkt_end);
      int unsigned acc;
      bit          live;
      live = !done;
      if (!done) begin
        if (bound == 0) begin
          conclude(ST_TRUNC);
        end else begin
          bound = bound - 1'b1;
          case (phase)
            PH_TAG: begin
              if (stage < EL_VALUE && b != TAG_CHAIN[stage]) conclude(ST_TAG);
              else phase = PH_LEN0;
            end
            PH_LEN0: begin
              if (!b[7]) begin
                length_known(b);
              end else if (b[6:0] == 7'd0) begin
                length_known(0);
              end else if (b[6:0] > MAX_LENGTH_BYTES) begin
                conclude(ST_TRUNC);
              end else begin
                len_accum = '0;
                len_bytes = LB_W'(b[6:0]);
                phase     = PH_LENX;
              end
            end
            PH_LENX: begin
              acc = len_accum * 256 + b;
              if (acc > PACKET_MAX) acc = PACKET_MAX + 1;
              len_accum = LEN_W'(acc);
              if (len_bytes > 0) len_bytes = len_bytes - 1'b1;
              if (len_bytes == 0) length_known(len_accum);
            end
            default: begin
              if (content > 0) content = content - 1'b1;
              if (stage == EL_OID) begin
                if (first_arc) begin
                  first_arc = 1'b0;
                  push(KIND_ARC, b / 8'd40, ST_OK);
                  push(KIND_ARC, b % 8'd40, ST_OK);
                end else begin
                  push(KIND_ARC, b, ST_OK);
                end
              end else if (stage >= EL_VALUE) begin
                push(KIND_VALUE, b, ST_OK);
              end
              if (content == 0) begin
                if (stage >= EL_VALUE) begin
                  conclude(ST_OK);
                end else begin
                  stage = stage + 1'b1;
                  phase = PH_TAG;
                end
              end
            end
          endcase
        end
      end
      if (pkt_end) begin
        if (!done) conclude(ST_TRUNC);
        restart();
      end
      return live;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(logic [1:0] kind, logic [7:0] value, logic [1:0] status,
                      logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing pending", kind, 0);
        return;
      end
      want = pending_results.pop_front();
      if (kind != want.kind) report("kind", kind, want.kind);
      if (value != want.value) report("item_value", value, want.value);
      if (status != want.status) report("status", status, want.status);
      if (last != want.last) report("last", last, want.last);
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       packet_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] kind_o;
  logic [7:0] item_value_o;
  logic [1:0] status_o;
  logic       last_o;

  varbind_scoreboard sb;
  int unsigned       in_idle_pct;
  int unsigned       out_idle_pct;
  int unsigned       parsed_bytes;
  int unsigned       cycle_count;

  snmp_response_varbind_parser_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .packet_end_i (packet_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .item_value_o (item_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(kind_o, item_value_o, status_o, last_o);
      end
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic byte_q_t random_bytes(int unsigned n);
    byte_q_t q;
    for (int unsigned i = 0; i < n; i++) q.insert(q.size(), 8'($urandom_range(255)));
    return q;
  endfunction

  function automatic byte_q_t join_bytes(byte_q_t a, byte_q_t b);
    byte_q_t q;
    q = a;
    foreach (b[i]) q.insert(q.size(), b[i]);
    return q;
  endfunction

  function automatic byte_q_t encode_len(int unsigned len);
    byte_q_t     q;
    int unsigned pick;
    int unsigned nb;
    pick = $urandom_range(9);
    if (len == 0 && pick == 0) begin
      q.insert(q.size(), LONG_FORM);
    end else if (len < 128 && pick < 7) begin
      q.insert(q.size(), 8'(len));
    end else begin
      nb = (len < 256) ? 1 : 2;
      if (nb < MAX_LENGTH_BYTES && $urandom_range(3) == 0) nb++;
      q.insert(q.size(), LONG_FORM | 8'(nb));
      for (int i = int'(nb) - 1; i >= 0; i--) q.insert(q.size(), 8'(len >> (8 * i)));
    end
    return q;
  endfunction

  function automatic byte_q_t tlv(logic [7:0] tag, byte_q_t body);
    byte_q_t q;
    q.insert(q.size(), tag);
    q = join_bytes(q, encode_len(body.size()));
    return join_bytes(q, body);
  endfunction

  function automatic byte_q_t build_response();
    byte_q_t     oid;
    byte_q_t     val;
    byte_q_t     varbind;
    byte_q_t     ints;
    byte_q_t     head;
    int unsigned val_len;
    val_len = ($urandom_range(19) == 0) ? $urandom_range(140, 120) : $urandom_range(8);
    oid     = random_bytes($urandom_range(6));
    val     = random_bytes(val_len);
    varbind = join_bytes(tlv(TAG_OID, oid), tlv(8'($urandom_range(255)), val));
    ints    = join_bytes(tlv(TAG_INT, random_bytes($urandom_range(4))),
                         tlv(TAG_INT, random_bytes($urandom_range(1))));
    ints    = join_bytes(ints, tlv(TAG_INT, random_bytes($urandom_range(1))));
    head    = join_bytes(tlv(TAG_INT, random_bytes($urandom_range(1))),
                         tlv(TAG_OCTETS, random_bytes($urandom_range(8))));
    head    = join_bytes(head, tlv(TAG_RESP,
                         join_bytes(ints, tlv(TAG_SEQ, tlv(TAG_SEQ, varbind)))));
    return tlv(TAG_SEQ, head);
  endfunction

  task automatic send_byte(logic [7:0] b, logic pkt_end);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    packet_end_i <= pkt_end;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_byte(b, pkt_end)) parsed_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_packet(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_packet();
    byte_q_t     q;
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(9);
    if (pick == 8) begin
      q = random_bytes($urandom_range(12, 1));
      if ($urandom_range(1)) q[0] = TAG_SEQ;
    end else begin
      q = build_response();
      if (pick == 6 || pick == 9) begin
        idx    = $urandom_range(q.size() - 1);
        q[idx] = 8'($urandom_range(255));
      end
      if (pick == 7 || pick == 9) begin
        idx = $urandom_range(q.size() - 1, 1);
        while (q.size() > idx) void'(q.pop_back());
      end
      if (pick < 6 && $urandom_range(2) == 0) begin
        q = join_bytes(q, random_bytes($urandom_range(3, 1)));
      end
    end
    send_packet(q);
  endtask

  // Bit 8 marks the packet's last byte.
  localparam logic [8:0] DIRECTED [21] = '{
    9'h1ff,
    9'h100,
    9'h030, 9'h084, 9'h100,
    9'h030, 9'h082, 9'h008, 9'h101,
    9'h030, 9'h001, 9'h002, 9'h100,
    9'h030, 9'h003, 9'h002, 9'h105,
    9'h030, 9'h080, 9'h102,
    9'h130
  };

  initial begin
    sb           = new();
    parsed_bytes = 0;
    in_idle_pct  = 6;
    out_idle_pct = 82;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    packet_end_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 82 : 0;
      out_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 6 : 0;
      while (parsed_bytes < 100 * (ph + 1)) send_random_packet();
      wait_drained();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* snmp_response_varbind_parser_top.f */
hdl/vbp_pkg.sv
hdl/vbp_parser.sv
hdl/vbp_res_fifo.sv
hdl/snmp_response_varbind_parser_top.sv
tb/snmp_response_varbind_parser_top_test.sv
